// File: hw/rtl/rtcep_pkg.sv
// Shared types, constants and helper functions for the RTC date to epoch converter.
// Used by rtcep_front, rtcep_queue, rtcep_back and rtc_date_to_epoch_seconds.
package rtcep_pkg;

  localparam int unsigned RAW_W       = 8;
  localparam int unsigned IN_W        = 6 * RAW_W;
  localparam int unsigned EPOCH_W     = 32;
  localparam int unsigned YEAR_W      = 12;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [YEAR_W-1:0]  CENTURY_BASE     = 12'd1900;
  localparam logic [YEAR_W-1:0]  EPOCH_YEAR       = 12'd1970;
  localparam logic [YEAR_W-1:0]  CENTURY_STEP     = 12'd100;
  localparam logic [EPOCH_W-1:0] EPOCH_DAY_OFFSET = 32'd719499;

  // Decoded time-of-day and day count, as handed from front to back.
  typedef struct packed {
    logic [EPOCH_W-1:0] days;
    logic [RAW_W-1:0]   hour;
    logic [RAW_W-1:0]   min;
    logic [RAW_W-1:0]   sec;
  } rtcep_work_t;

  // BCD decode with no nibble check: low + 10 * high, so 0xFF gives 165.
  function automatic logic [RAW_W-1:0] decode_byte(input logic [RAW_W-1:0] raw,
                                                   input logic bcd);
    logic [RAW_W-1:0] hi;
    hi = {4'b0, raw[7:4]};
    if (bcd) begin
      decode_byte = {4'b0, raw[3:0]} + (hi << 3) + (hi << 1);
    end else begin
      decode_byte = raw;
    end
  endfunction

endpackage

// File: hw/rtl/rtcep_front.sv
// Front end: BCD decode, century fix-up and month rotation, then the Gauss day count.
// Two elastic stages; depends on rtcep_pkg.
module rtcep_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              bcd,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rtcep_pkg::IN_W-1:0]        in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output rtcep_pkg::rtcep_work_t            out_work
);

  localparam int unsigned RW = rtcep_pkg::RAW_W;
  localparam int unsigned YW = rtcep_pkg::YEAR_W;

  // stage A: decoded fields
  logic          a_valid;
  logic [RW-1:0] a_sec, a_min, a_hour, a_day, a_mon;
  logic [YW-1:0] a_year;
  logic          a_ready;

  // stage B: day count
  logic          b_valid;
  rtcep_pkg::rtcep_work_t b_work;
  logic          b_ready;

  logic [RW-1:0] d_sec, d_min, d_hour, d_day, d_mon, d_year;
  logic [YW-1:0] year_c, year_r;
  logic [RW-1:0] mon_r;

  logic [YW-1:0] cent, quad;
  logic [10:0]   mon7;
  logic [23:0]   mon7_scaled;
  logic [12:0]   mon30;
  logic [12:0]   mon_days;
  logic [rtcep_pkg::EPOCH_W-1:0] days_next;

  assign b_ready   = !b_valid || out_ready;
  assign a_ready   = !a_valid || b_ready;
  assign in_ready  = a_ready;
  assign out_valid = b_valid;
  assign out_work  = b_work;

  always_comb begin
    d_sec  = rtcep_pkg::decode_byte(in_data[0*RW +: RW], bcd);
    d_min  = rtcep_pkg::decode_byte(in_data[1*RW +: RW], bcd);
    d_hour = rtcep_pkg::decode_byte(in_data[2*RW +: RW], bcd);
    d_day  = rtcep_pkg::decode_byte(in_data[3*RW +: RW], bcd);
    d_mon  = rtcep_pkg::decode_byte(in_data[4*RW +: RW], bcd);
    d_year = rtcep_pkg::decode_byte(in_data[5*RW +: RW], bcd);

    year_c = rtcep_pkg::CENTURY_BASE + {{(YW-RW){1'b0}}, d_year};
    if (year_c < rtcep_pkg::EPOCH_YEAR) begin
      year_c = year_c + rtcep_pkg::CENTURY_STEP;
    end

    // March counts as month 1, February as month 12 of the previous year
    if (d_mon <= 8'd2) begin
      mon_r  = d_mon + 8'd10;
      year_r = year_c - 12'd1;
    end else begin
      mon_r  = d_mon - 8'd2;
      year_r = year_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
    if (a_ready && in_valid) begin
      a_sec  <= d_sec;
      a_min  <= d_min;
      a_hour <= d_hour;
      a_day  <= d_day;
      a_mon  <= mon_r;
      a_year <= year_r;
    end
  end

  // year stays in 1969..2155, so the century terms come from compares
  always_comb begin
    if (a_year >= 12'd2100) begin
      cent = 12'd21;
    end else if (a_year >= 12'd2000) begin
      cent = 12'd20;
    end else begin
      cent = 12'd19;
    end
    quad = (a_year >= 12'd2000) ? 12'd5 : 12'd4;

    // 367*m/12 = 30*m + 7*m/12; 7*m/12 by reciprocal 5462/2^16 (exact for 7*m < 8190)
    mon7        = ({3'b0, a_mon} << 3) - {3'b0, a_mon};
    mon7_scaled = {13'b0, mon7} * 24'd5462;
    mon30       = ({5'b0, a_mon} << 5) - ({5'b0, a_mon} << 1);
    mon_days    = mon30 + {5'b0, mon7_scaled[23:16]};

    days_next = 32'(a_year) * 32'd365
              + 32'(a_year >> 2) - 32'(cent) + 32'(quad)
              + 32'(mon_days) + 32'(a_day)
              - rtcep_pkg::EPOCH_DAY_OFFSET;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
    if (b_ready && a_valid) begin
      b_work.days <= days_next;
      b_work.hour <= a_hour;
      b_work.min  <= a_min;
      b_work.sec  <= a_sec;
    end
  end

endmodule

// File: hw/rtl/rtcep_queue.sv
// Small FIFO of day-count words between the front and back ends.
// Depends on rtcep_pkg for the word type.
module rtcep_queue #(
  parameter int unsigned DEPTH = rtcep_pkg::QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  rtcep_pkg::rtcep_work_t in_work,
  output logic                   out_valid,
  input  logic                   out_ready,
  output rtcep_pkg::rtcep_work_t out_work
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  rtcep_pkg::rtcep_work_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push, pop;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign out_work  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_work;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// File: hw/rtl/rtcep_back.sv
// Back end: scales the day count to seconds, mod 2^32, in three elastic stages.
// The last stage is the output register; depends on rtcep_pkg.
module rtcep_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rtcep_pkg::rtcep_work_t        in_work,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rtcep_pkg::EPOCH_W-1:0] out_seconds
);

  localparam int unsigned EW = rtcep_pkg::EPOCH_W;
  localparam int unsigned RW = rtcep_pkg::RAW_W;

  logic          v1, v2, v3;
  logic          r1, r2, r3;
  logic [EW-1:0] hours1, mins2, secs3;
  logic [RW-1:0] min1, sec1, sec2;

  assign r3          = !v3 || out_ready;
  assign r2          = !v2 || r3;
  assign r1          = !v1 || r2;
  assign in_ready    = r1;
  assign out_valid   = v3;
  assign out_seconds = secs3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
    end
    if (r1 && in_valid) begin
      hours1 <= in_work.days * 32'd24 + EW'(in_work.hour);
      min1   <= in_work.min;
      sec1   <= in_work.sec;
    end
    if (r2 && v1) begin
      mins2 <= hours1 * 32'd60 + EW'(min1);
      sec2  <= sec1;
    end
    if (r3 && v2) begin
      secs3 <= mins2 * 32'd60 + EW'(sec2);
    end
  end

endmodule

// File: hw/rtl/rtc_date_to_epoch_seconds.sv
// Top level of the RTC date to epoch seconds converter.
// Instantiates rtcep_front, rtcep_queue and rtcep_back; depends on rtcep_pkg.
//
// Converts six raw clock register bytes (seconds, minutes, hours, day, month,
// two-digit year) into seconds since 1970-01-01 00:00:00, modulo 2^32. Bytes
// are BCD-decoded when data_is_bcd is set (reset value 1); nothing is range
// checked. One word is taken and one result given per clock, sustained while
// m_axis_tready stays high. A result shows on m_axis_tvalid once its word has passed
// six registers, the first loaded at the accepting edge: two front stages
// (decode, day count), one through the queue, and three back stages
// (hours, minutes, seconds scaling). The queue of QUEUE_DEPTH words lets the
// front keep accepting while the output stalls. Write cfg_wr_data only while
// no conversion is in flight.
module rtc_date_to_epoch_seconds #(
  parameter int unsigned QUEUE_DEPTH = rtcep_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // raw_seconds[7:0], raw_minutes[15:8], raw_hours[23:16],
  // raw_day[31:24], raw_month[39:32], raw_year[47:40]
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // epoch_seconds[31:0]
  output logic [31:0] m_axis_tdata
);

  logic data_is_bcd;

  logic                   f_valid, f_ready;
  rtcep_pkg::rtcep_work_t f_work;
  logic                   q_valid, q_ready;
  rtcep_pkg::rtcep_work_t q_work;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_is_bcd <= 1'b1;
    end else if (cfg_wr_en) begin
      data_is_bcd <= cfg_wr_data;
    end
  end

  rtcep_front u_front (
    .clk       (clk),
    .rst       (rst),
    .bcd       (data_is_bcd),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_work  (f_work)
  );

  rtcep_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_work   (f_work),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_work  (q_work)
  );

  rtcep_back u_back (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (q_valid),
    .in_ready    (q_ready),
    .in_work     (q_work),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_seconds (m_axis_tdata)
  );

endmodule

// File: tb/rtc_date_to_epoch_seconds_test.sv
// Self-checking testbench for rtc_date_to_epoch_seconds: directed dates, then random
// register words in BCD and binary mode under varying stream back-pressure.
// Depends on rtcep_pkg and the RTL of rtc_date_to_epoch_seconds only.
`timescale 1ns / 100ps

module rtc_date_to_epoch_seconds_test;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned SEGMENTS      = 6;
  localparam int unsigned SEGMENT_WORDS = 232;
  localparam int unsigned DIRECTED_ROWS = 22;

  localparam logic [63:0] YEAR_BASE      = 64'd1900;
  localparam logic [63:0] FIRST_YEAR     = 64'd1970;
  localparam logic [63:0] CENTURY_YEARS  = 64'd100;
  localparam logic [63:0] DAY_NUM_OFFSET = 64'd719499;

  // Register bytes as they sit on tdata: seconds in the low byte, year on top.
  typedef struct packed {
    logic [7:0] year;
    logic [7:0] month;
    logic [7:0] day;
    logic [7:0] hours;
    logic [7:0] minutes;
    logic [7:0] seconds;
  } raw_date_t;

  typedef struct packed {
    logic        bcd;
    logic        known;
    logic [31:0] value;
    raw_date_t   word;
  } date_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;

  logic [31:0] expected_epochs[$];
  date_row_t   directed_rows[DIRECTED_ROWS];
  logic        bcd_mode;
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  int unsigned cycle_count;
  int unsigned err_count;
  int unsigned checked_count;
  int unsigned mode_writes;

  rtc_date_to_epoch_seconds DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             expected_epochs.size());
    $display("rtc_date_to_epoch_seconds verification failed");
    $finish;
  end

  function automatic logic [63:0] field_value(input logic [7:0] b, input logic bcd);
    if (bcd) begin
      return 64'(b[3:0]) + 64'(b[7:4]) * 64'd10;
    end
    return 64'(b);
  endfunction

  // Gauss day count with March as month 1; all arithmetic wraps, low 32 bits kept.
  function automatic logic [31:0] epoch_of(input raw_date_t w, input logic bcd);
    logic [63:0] yr;
    logic [63:0] mon;
    logic [63:0] days;
    logic [63:0] total;
    yr  = field_value(w.year, bcd) + YEAR_BASE;
    mon = field_value(w.month, bcd);
    if (yr < FIRST_YEAR) begin
      yr = yr + CENTURY_YEARS;
    end
    if (mon <= 64'd2) begin
      mon = mon + 64'd10;
      yr  = yr - 64'd1;
    end else begin
      mon = mon - 64'd2;
    end
    days = yr / 64'd4 - yr / 64'd100 + yr / 64'd400 + (64'd367 * mon) / 64'd12
         + field_value(w.day, bcd) + yr * 64'd365 - DAY_NUM_OFFSET;
    total = ((days * 64'd24 + field_value(w.hours, bcd)) * 64'd60
            + field_value(w.minutes, bcd)) * 64'd60 + field_value(w.seconds, bcd);
    return total[31:0];
  endfunction

  function automatic logic [7:0] to_register(input int unsigned v, input logic bcd);
    if (bcd) begin
      return {4'(v / 10), 4'(v % 10)};
    end
    return 8'(v);
  endfunction

  // Mostly plausible calendar dates in the current encoding, the rest raw noise.
  function automatic raw_date_t random_date(input logic bcd);
    raw_date_t w;
    if ($urandom_range(99) < 30) begin
      w = {$urandom(), 16'($urandom())};
    end else begin
      w.seconds = to_register($urandom_range(59), bcd);
      w.minutes = to_register($urandom_range(59), bcd);
      w.hours   = to_register($urandom_range(23), bcd);
      w.day     = to_register($urandom_range(31, 1), bcd);
      w.month   = to_register($urandom_range(12, 1), bcd);
      w.year    = to_register($urandom_range(99), bcd);
    end
    return w;
  endfunction

  task automatic push_word(input raw_date_t w, input logic known, input logic [31:0] value);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_epochs.push_back(known ? value : epoch_of(w, bcd_mode));
  endtask

  // Hold the sender until every result is back and the pipe has emptied.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_epochs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic bcd);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= bcd;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    bcd_mode    = bcd;
    mode_writes++;
  endtask

  // Result side: random stalls, every accepted word checked in order.
  initial begin
    logic [31:0] want;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        checked_count++;
        if (expected_epochs.size() == 0) begin
          $error("epoch_seconds: unexpected word 0x%08h", m_axis_tdata);
          err_count++;
        end else begin
          want = expected_epochs.pop_front();
          if (m_axis_tdata !== want) begin
            $error("epoch_seconds mismatch: expected %0d, actual %0d", want, m_axis_tdata);
            err_count++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    cycle_count    = 0;
    err_count      = 0;
    checked_count  = 0;
    mode_writes    = 0;
    bcd_mode       = 1'b1;
    send_gap_pct   = 18;
    recv_stall_pct = 75;
    rst           <= 1'b1;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;

    // bcd, known, value, word = year_month_day_hour_min_sec
    directed_rows = '{
      '{1'b1, 1'b1, 32'd0,          48'h70_01_01_00_00_00},  // epoch
      '{1'b1, 1'b1, 32'd946684800,  48'h00_01_01_00_00_00},
      '{1'b1, 1'b1, 32'd2147483647, 48'h38_01_19_03_14_07},  // last signed second
      '{1'b1, 1'b1, 32'd2147483648, 48'h38_01_19_03_14_08},
      '{1'b1, 1'b1, 32'd4294880896, 48'h70_01_00_00_00_00},  // day zero wraps below epoch
      '{1'b1, 1'b0, 32'd0,          48'h00_00_00_00_00_00},
      '{1'b1, 1'b0, 32'd0,          48'hFF_FF_FF_FF_FF_FF},  // nibbles above nine
      '{1'b1, 1'b0, 32'd0,          48'h99_99_99_99_99_99},
      '{1'b1, 1'b0, 32'd0,          48'h24_02_29_23_59_59},  // leap day
      '{1'b1, 1'b0, 32'd0,          48'h69_02_28_12_30_45},
      '{1'b1, 1'b0, 32'd0,          48'h99_12_31_23_59_59},
      '{1'b1, 1'b0, 32'd0,          48'h45_13_05_10_10_10},  // month past twelve
      '{1'b1, 1'b0, 32'd0,          48'h3A_0F_AA_55_5A_A5},
      '{1'b1, 1'b0, 32'd0,          48'h69_03_01_00_00_00},
      '{1'b0, 1'b1, 32'd0,          48'h46_01_01_00_00_00},  // epoch, binary
      '{1'b0, 1'b1, 32'd951868800,  48'h00_03_01_00_00_00},
      '{1'b0, 1'b0, 32'd0,          48'hFF_FF_FF_FF_FF_FF},
      '{1'b0, 1'b0, 32'd0,          48'h00_00_00_00_00_00},
      '{1'b0, 1'b0, 32'd0,          48'h55_AA_55_AA_55_AA},
      '{1'b0, 1'b0, 32'd0,          48'h45_02_1C_17_3B_3B},
      '{1'b0, 1'b0, 32'd0,          48'h63_0C_1F_17_3B_3B},
      '{1'b0, 1'b0, 32'd0,          48'h80_01_01_00_00_00}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part starts on the reset mode, no write yet.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].bcd != bcd_mode) begin
        write_mode(directed_rows[i].bcd);
      end
      push_word(directed_rows[i].word, directed_rows[i].known, directed_rows[i].value);
    end

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 2)
        0: begin
          send_gap_pct   = 18;
          recv_stall_pct = 75;
        end
        1: begin
          send_gap_pct   = 75;
          recv_stall_pct = 18;
        end
        default: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
      endcase
      write_mode((seg % 2) == 0);
      for (int n = 0; n < SEGMENT_WORDS; n++) begin
        if (n == SEGMENT_WORDS / 2) begin
          drain_results();
        end
        push_word(random_date(bcd_mode), 1'b0, 32'd0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (expected_epochs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("checked %0d converted words (%0d directed), %0d mode writes, BCD and binary",
             checked_count, DIRECTED_ROWS, mode_writes);
    $display("stall mixes: sender 18/receiver 75, sender 75/receiver 18, no stalls");
    if (err_count == 0) begin
      $display("rtc_date_to_epoch_seconds verification clean");
    end else begin
      $display("rtc_date_to_epoch_seconds verification failed");
    end
    $finish;
  end

endmodule
